// ===== hdl/interleaved_centered_fir_top_macros.svh =====
// Assertion macros shared by the centered FIR checker.
`ifndef INTERLEAVED_CENTERED_FIR_TOP_MACROS_SVH
`define INTERLEAVED_CENTERED_FIR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ICFIR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ICFIR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/icfir_pkg.sv =====
// Types and constants of the interleaved centered FIR.
package icfir_pkg;

  localparam int DATA_W     = 24;
  localparam int FUNC_W     = 2;
  localparam int COEF_IDX_W = 6;
  localparam int TAP_REG_W  = 7;
  localparam int CH_REG_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int Q_SHIFT    = 22;

  // item functions
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND
  } icfir_state_t;

endpackage

// ===== hdl/icfir_if.sv =====
// Valid/ready channel interfaces of the interleaved centered FIR.
interface icfir_in_if;
  logic                                       valid;
  logic                                       ready;
  logic        [icfir_pkg::FUNC_W-1:0]        func;
  logic        [icfir_pkg::COEF_IDX_W-1:0]    coef_index;
  logic signed [icfir_pkg::DATA_W-1:0]        coef_value;
  logic signed [icfir_pkg::DATA_W-1:0]        sample_in;
  modport source (output valid, func, coef_index, coef_value, sample_in, input ready);
  modport sink   (input valid, func, coef_index, coef_value, sample_in, output ready);
endinterface

interface icfir_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [icfir_pkg::DATA_W-1:0] y_out;
  logic                                saturated;
  modport source (output valid, y_out, saturated, input ready);
  modport sink   (input valid, y_out, saturated, output ready);
endinterface

interface icfir_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [icfir_pkg::CFG_IDX_W-1:0]     index;
  logic [icfir_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/interleaved_centered_fir_top.sv =====
// Centered FIR over a channel-interleaved stream, one shared multiply-accumulate.
//
//  channel  dir  word                                       handshake
//  in_ch    in   func, coef_index, coef_value, sample_in    valid/ready
//  out_ch   out  y_out, saturated                           valid/ready
//  cfg_ch   in   index, data                                valid/ready (always ready)
//
// Load, clear and a push without enough lookahead leave in_ch ready.
// A push that yields a word runs the MAC over taps, taps being tap_count clamped to
// 1..MAX_TAPS: the single MAC walks one tap a cycle (memory read, multiply,
// accumulate), then rounds.
// in_ch is not ready while the MAC runs or a rounded word waits for the output register.
// rst_n (sync, active low) resets config, coefficient valid bits and history counters;
// the delay line needs no clearing, only pushes since the last clear are read.
module interleaved_centered_fir_top #(
  parameter int MAX_TAPS     = 64,
  parameter int MAX_CHANNELS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  icfir_in_if.sink       in_ch,
  icfir_out_if.source    out_ch,
  icfir_cfg_if.sink      cfg_ch
);
  import icfir_pkg::*;

  localparam int LINE_DEPTH = MAX_TAPS * MAX_CHANNELS;
  localparam int PTR_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
  localparam int KIDX_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_W      = $clog2(MAX_TAPS + 1);
  localparam int CH_W       = $clog2(MAX_CHANNELS + 1);
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = PROD_W + KIDX_W + 1;

  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(LINE_DEPTH - 1);
  localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(LINE_DEPTH);
  localparam logic [PTR_W:0]     DEPTH_X  = (PTR_W + 1)'(LINE_DEPTH);
  localparam logic [PTR_W:0]     DEPTH_M1 = (PTR_W + 1)'(LINE_DEPTH - 1);
  localparam logic signed [ACC_W-1:0] ONE_A  = 1;
  localparam logic signed [ACC_W-1:0] BIAS_A = ONE_A <<< (Q_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX_A = (ONE_A <<< (DATA_W - 1)) - ONE_A;
  localparam logic signed [ACC_W-1:0] Y_MIN_A = -(ONE_A <<< (DATA_W - 1));

  // configuration
  logic [TAP_REG_W-1:0] tap_count_r;
  logic [CH_REG_W-1:0]  channel_count_r;
  logic [TAP_W-1:0]     taps_eff;
  logic [CH_W-1:0]      ch_eff;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r     <= TAP_REG_W'(1);
      channel_count_r <= CH_REG_W'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_TAP_COUNT:     tap_count_r     <= cfg_ch.data[TAP_REG_W-1:0];
        REG_CHANNEL_COUNT: channel_count_r <= cfg_ch.data[CH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tap_count_r == '0) begin
      taps_eff = TAP_W'(1);
    end else if (int'(tap_count_r) > MAX_TAPS) begin
      taps_eff = TAP_W'(MAX_TAPS);
    end else begin
      taps_eff = TAP_W'(tap_count_r);
    end
    if (channel_count_r == '0) begin
      ch_eff = CH_W'(1);
    end else if (int'(channel_count_r) > MAX_CHANNELS) begin
      ch_eff = CH_W'(MAX_CHANNELS);
    end else begin
      ch_eff = CH_W'(channel_count_r);
    end
  end

  // window geometry
  logic [TAP_W-1:0]      taps_m1;
  logic [TAP_W-1:0]      la_taps;
  logic [TAP_W+CH_W-1:0] la_prod;
  logic [TAP_W+CH_W-1:0] start_prod;
  logic [CNT_W-1:0]      lookahead;
  logic [PTR_W-1:0]      back_start;

  always_comb begin
    taps_m1    = taps_eff - TAP_W'(1);
    la_taps    = taps_m1 - (taps_eff >> 1);
    la_prod    = (TAP_W + CH_W)'(la_taps) * (TAP_W + CH_W)'(ch_eff);
    start_prod = (TAP_W + CH_W)'(taps_m1) * (TAP_W + CH_W)'(ch_eff);
    lookahead  = CNT_W'(la_prod);
    back_start = PTR_W'(start_prod);
  end

  // sequencer state
  icfir_state_t         state_r, state_nxt;
  logic [KIDX_W-1:0]    k_r, k_nxt;
  logic [PTR_W-1:0]     back_r, back_nxt;
  logic [PTR_W-1:0]     wp_r, wp_nxt;
  logic [CNT_W-1:0]     pushed_r, pushed_nxt;
  logic [CNT_W-1:0]     pushed_inc;
  logic                 in_acc;
  logic                 push_wr;
  logic                 issue;
  logic                 acc_clr;
  logic                 out_load;

  // MAC pipeline
  logic                       s1_valid_r, s2_valid_r;
  logic                       s1_use_r;
  logic signed [DATA_W-1:0]   dl_q_r, cf_q_r;
  logic signed [PROD_W-1:0]   prod_full, prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [PTR_W:0]             slot_sum;
  logic [PTR_W-1:0]           slot;
  logic                       in_range;

  // output register
  logic                       out_valid_r;
  logic signed [DATA_W-1:0]   out_y_r;
  logic                       out_sat_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign push_wr     = in_acc && ((in_ch.func == FUNC_PUSH) || (in_ch.func == FUNC_FLUSH));
  assign pushed_inc  = (pushed_r == CNT_FULL) ? pushed_r : pushed_r + CNT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    back_nxt   = back_r;
    wp_nxt     = wp_r;
    pushed_nxt = pushed_r;
    issue      = 1'b0;
    acc_clr    = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.func)
            FUNC_PUSH, FUNC_FLUSH: begin
              wp_nxt     = (wp_r == PTR_LAST) ? '0 : wp_r + PTR_W'(1);
              pushed_nxt = pushed_inc;
              if (pushed_inc > lookahead) begin
                state_nxt = ST_MAC;
                k_nxt     = '0;
                back_nxt  = back_start;
                acc_clr   = 1'b1;
              end
            end
            FUNC_CLEAR: begin
              wp_nxt     = '0;
              pushed_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        issue    = 1'b1;
        k_nxt    = k_r + KIDX_W'(1);
        back_nxt = back_r - PTR_W'(ch_eff);
        if (k_r == KIDX_W'(taps_m1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid_r && !s2_valid_r) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      k_r      <= '0;
      back_r   <= '0;
      wp_r     <= '0;
      pushed_r <= '0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      back_r   <= back_nxt;
      wp_r     <= wp_nxt;
      pushed_r <= pushed_nxt;
    end
  end

  // slot of the tap: newest is wp - 1, older ones further back, wrapped once
  always_comb begin
    slot_sum = {1'b0, wp_r} + DEPTH_M1 - {1'b0, back_r};
    slot     = (slot_sum >= DEPTH_X) ? PTR_W'(slot_sum - DEPTH_X) : PTR_W'(slot_sum);
    in_range = CNT_W'(back_r) < pushed_r;
  end

  // delay line
  logic signed [DATA_W-1:0] delay_mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (push_wr) begin
      delay_mem[wp_r] <= (in_ch.func == FUNC_PUSH) ? in_ch.sample_in : '0;
    end
    dl_q_r <= delay_mem[slot];
  end

  // coefficient table, unwritten entries read as zero through valid bits
  logic signed [DATA_W-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]      coef_valid_r;
  logic                     coef_wr;
  logic [KIDX_W-1:0]        coef_widx;

  assign coef_wr   = in_acc && (in_ch.func == FUNC_LOAD) && (int'(in_ch.coef_index) < MAX_TAPS);
  assign coef_widx = KIDX_W'(in_ch.coef_index);

  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[coef_widx] <= in_ch.coef_value;
    end
    cf_q_r <= coef_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_valid_r <= '0;
    end else if (coef_wr) begin
      coef_valid_r[coef_widx] <= 1'b1;
    end
  end

  // multiply and accumulate: 24 x 24 signed, exact in PROD_W bits
  assign prod_full = dl_q_r * cf_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_use_r <= in_range && coef_valid_r[k_r];
    prod_r   <= s1_use_r ? prod_full : '0;
    if (acc_clr) begin
      acc_r <= '0;
    end else if (s2_valid_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, floor shift, clamp
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [DATA_W-1:0] y_sel;
  logic                     sat_sel;

  always_comb begin
    rnd     = acc_r + BIAS_A;
    shifted = rnd >>> Q_SHIFT;
    if (shifted > Y_MAX_A) begin
      y_sel   = DATA_W'(Y_MAX_A);
      sat_sel = 1'b1;
    end else if (shifted < Y_MIN_A) begin
      y_sel   = DATA_W'(Y_MIN_A);
      sat_sel = 1'b1;
    end else begin
      y_sel   = shifted[DATA_W-1:0];
      sat_sel = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_y_r   <= y_sel;
      out_sat_r <= sat_sel;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.y_out     = out_y_r;
  assign out_ch.saturated = out_sat_r;

endmodule

// ===== hdl/icfir_checker.sv =====
// Port-level checks of the centered FIR, bound to the top level.
`include "interleaved_centered_fir_top_macros.svh"

module icfir_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [icfir_pkg::FUNC_W-1:0]        in_func,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [icfir_pkg::DATA_W-1:0] out_y,
  input logic                                out_sat
);
  import icfir_pkg::*;

  localparam logic signed [DATA_W-1:0] Y_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Y_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

  `ICFIR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_y) && $stable(out_sat), "stalled output word changed")
  `ICFIR_ASSERT_NXT(a_short_items, in_valid && in_ready && (in_func == FUNC_LOAD || in_func == FUNC_CLEAR), in_ready, "load or clear kept the input busy")
  `ICFIR_ASSERT_NOW(a_sat_clamp, out_valid && out_sat, out_y == Y_MAX || out_y == Y_MIN, "saturated word not at a rail")
  `ICFIR_ASSERT_NOW(a_word_from_busy, $rose(out_valid), !$past(in_ready), "output word appeared while input was idle")

endmodule

bind interleaved_centered_fir_top icfir_checker u_icfir_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_y     (out_ch.y_out),
  .out_sat   (out_ch.saturated)
);
